[src/rvu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp velocity update package
// Shared widths, defaults and the data word that moves through the root chain.
// ----------------------------------------------------------------------------
package rvu_pkg;

	// Width of every fixed-point field on the ports.
	localparam int DATA_W = 32;

	// Width of squared velocities, products and the root radicand.
	localparam int NUM_W = 2 * DATA_W;

	// One root cell settles one result bit.
	localparam int ROOT_STEPS = NUM_W / 2;

	// Default number of fraction bits in the velocity format.
	localparam int FRAC_BITS_DEF = 12;

	// Word carried from cell to cell.
	typedef struct packed {
		logic [NUM_W-1:0]  num;      // remaining radicand
		logic [NUM_W-1:0]  res;      // partial root
		logic              ovr;      // result is fixed, root is ignored
		logic [DATA_W-1:0] ovr_val;  // fixed result value
	} root_t;

endpackage

[src/rvu_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp velocity update front end
// Forms v*v and a*s, then the radicand and the fixed-result cases.
// ----------------------------------------------------------------------------
module rvu_prep #(
	parameter int FRAC_BITS = rvu_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rvu_pkg::DATA_W-1:0] rate,
	input  logic [rvu_pkg::DATA_W-1:0] cur_vel,
	input  logic [rvu_pkg::DATA_W-1:0] tgt_vel,
	input  logic [rvu_pkg::DATA_W-1:0] steps,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rvu_pkg::root_t            out_data
);
	import rvu_pkg::*;

	// Total left shift of a*s: the factor two and the fraction scaling.
	localparam int SH = FRAC_BITS + 1;

	logic              valid_s1;
	logic              valid_s2;
	logic              ready_s1;
	logic              ready_s2;
	logic [NUM_W-1:0]  as_s1;
	logic [NUM_W-1:0]  vsq_s1;
	logic              byp_s1;
	logic              up_s1;
	logic [DATA_W-1:0] vel_s1;
	root_t             data_s2;
	root_t             data_d;
	logic [NUM_W+SH-1:0] prod_w;
	logic [SH-1:0]     prod_hi;
	logic [NUM_W-1:0]  prod_lo;
	logic [NUM_W:0]    sum_w;
	logic [NUM_W:0]    diff_w;

	// Each stage takes a beat when it is empty or its successor moves.
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage one: the two products and the direction of the ramp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			as_s1  <= NUM_W'(rate) * NUM_W'(steps);
			vsq_s1 <= NUM_W'(cur_vel) * NUM_W'(cur_vel);
			byp_s1 <= (rate == '0) || (steps == '0) || (cur_vel == tgt_vel);
			up_s1  <= cur_vel < tgt_vel;
			vel_s1 <= cur_vel;
		end
	end

	// The scaled product is exact; its upper part only signals overflow.
	assign prod_w  = {{SH{1'b0}}, as_s1} << SH;
	assign prod_hi = prod_w[NUM_W+SH-1:NUM_W];
	assign prod_lo = prod_w[NUM_W-1:0];
	assign sum_w   = {1'b0, vsq_s1} + {1'b0, prod_lo};
	assign diff_w  = {1'b0, vsq_s1} - {1'b0, prod_lo};

	// Pick the radicand or a fixed result.
	always_comb begin
		data_d.num     = '0;
		data_d.res     = '0;
		data_d.ovr     = 1'b0;
		data_d.ovr_val = '0;
		if (byp_s1) begin
			data_d.ovr     = 1'b1;
			data_d.ovr_val = vel_s1;
		end else if (up_s1) begin
			if ((prod_hi != '0) || sum_w[NUM_W]) begin
				data_d.ovr     = 1'b1;
				data_d.ovr_val = '1;
			end else begin
				data_d.num = sum_w[NUM_W-1:0];
			end
		end else begin
			if ((prod_hi != '0) || diff_w[NUM_W] || (diff_w[NUM_W-1:0] == '0)) begin
				data_d.ovr     = 1'b1;
				data_d.ovr_val = '0;
			end else begin
				data_d.num = diff_w[NUM_W-1:0];
			end
		end
	end

	// Stage two register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			data_s2 <= data_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

[src/rvu_root_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp velocity update root cell
// One step of the bitwise integer square root, registered, with handshake.
// ----------------------------------------------------------------------------
module rvu_root_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rvu_pkg::root_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rvu_pkg::root_t out_data
);
	import rvu_pkg::*;

	// Trial bit of this step; the first cell tries the top even bit.
	localparam int BIT_POS = NUM_W - 2 - 2 * STEP;
	localparam logic [NUM_W-1:0] BIT_VAL = {{(NUM_W-1){1'b0}}, 1'b1} << BIT_POS;

	logic             valid_q;
	root_t            data_q;
	root_t            data_d;
	logic [NUM_W-1:0] trial;

	assign in_ready = !valid_q || out_ready;

	// Subtract the trial value when it fits and set the result bit.
	assign trial = in_data.res + BIT_VAL;

	always_comb begin
		data_d = in_data;
		if (in_data.num >= trial) begin
			data_d.num = in_data.num - trial;
			data_d.res = (in_data.res >> 1) + BIT_VAL;
		end else begin
			data_d.res = in_data.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[src/ramp_velocity_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp velocity update
// Velocity after a number of steps at constant acceleration or deceleration.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one beat per update: rate, current velocity,
//   target velocity and step count. The master channel returns one beat with
//   the new velocity for each input beat, in order.
//   Below target the result is floor(sqrt(v*v + 2*a*s*2^FRAC_BITS)), above
//   target floor(sqrt(v*v - 2*a*s*2^FRAC_BITS)), floored at zero and
//   saturated at all ones. Zero rate, zero steps or equal velocities return
//   the current velocity.
//   An accepted input beat passes the multiplier stage and the radicand
//   stage, then the register in each of the 32 root cells, one result bit
//   per cell. The chain takes a new beat every cycle while the receiver
//   keeps up, so throughput is one update per cycle.
//   Reset empties every stage; no beat is presented until new input arrives.
//   When the receiver stalls, the last cell holds its beat and the stages
//   behind it keep filling until the chain is full; s_tready then drops.
// ----------------------------------------------------------------------------
module ramp_velocity_update_top #(
	parameter int FRAC_BITS = rvu_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// rate [31:0], current_velocity [63:32], target_velocity [95:64],
	// step_count [127:96]
	input  logic [4*rvu_pkg::DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// new_velocity [31:0]
	output logic [rvu_pkg::DATA_W-1:0]    m_tdata
);
	import rvu_pkg::*;

	logic  chain_valid [ROOT_STEPS+1];
	logic  chain_ready [ROOT_STEPS+1];
	root_t chain_data  [ROOT_STEPS+1];
	root_t last;

	// Products, radicand and fixed results.
	rvu_prep #(
		.FRAC_BITS(FRAC_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.rate      (s_tdata[DATA_W-1:0]),
		.cur_vel   (s_tdata[2*DATA_W-1:DATA_W]),
		.tgt_vel   (s_tdata[3*DATA_W-1:2*DATA_W]),
		.steps     (s_tdata[4*DATA_W-1:3*DATA_W]),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	// Row of root cells, one result bit each.
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_cell
		rvu_root_cell #(
			.STEP(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	// The last cell register is the output register.
	assign chain_ready[ROOT_STEPS] = m_tready;
	assign m_tvalid                = chain_valid[ROOT_STEPS];
	assign last                    = chain_data[ROOT_STEPS];

	// Fixed results win; a root above the field range saturates.
	always_comb begin
		if (last.ovr) begin
			m_tdata = last.ovr_val;
		end else if (last.res[NUM_W-1:DATA_W] != '0) begin
			m_tdata = '1;
		end else begin
			m_tdata = last.res[DATA_W-1:0];
		end
	end

endmodule

[src/rvu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp velocity update port checker
// Watches the top-level channels for stall and flow-control behavior.
// ----------------------------------------------------------------------------
module rvu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [rvu_pkg::DATA_W-1:0] m_tdata
);

	// A stalled output beat stays and keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// With the output stage empty the whole chain has room.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused while output stage is empty");

	// A receiver that takes every beat never stalls the input.
	a_pass_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input refused while receiver is ready");

	// A waiting input beat is taken once the receiver drains the output.
	a_no_lock: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready && m_tvalid && m_tready |-> ##0 s_tready)
		else $error("input stalled although chain moves");

endmodule

bind ramp_velocity_update_top rvu_checker u_rvu_checker (.*);

[tb/sv/ramp_velocity_update_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp velocity update testbench
// Streams directed corner cases and about eleven hundred random updates into
// the block under random idling on both channels. Each accepted input beat is
// scored by an independent fixed-point predictor, and each output beat is
// compared in order with the oldest predicted velocity.
// ----------------------------------------------------------------------------
module ramp_velocity_update_top_tb;

	import rvu_pkg::*;

	localparam int FRAC_BITS    = FRAC_BITS_DEF;
	localparam int HALF_PERIOD  = 4;
	localparam int LATENCY      = 34;
	localparam int IDLE_PCT     = 38;
	localparam int N_RANDOM     = 1100;
	localparam int CALM_FIRST   = 600;
	localparam int CALM_LAST    = 800;
	localparam int DRAIN_POINT  = 450;
	localparam int HOLD_POINT   = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 4000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	// One velocity update request.
	typedef struct packed {
		logic [DATA_W-1:0] steps;
		logic [DATA_W-1:0] tgt_v;
		logic [DATA_W-1:0] cur_v;
		logic [DATA_W-1:0] rate;
	} ramp_req_t;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [4*DATA_W-1:0]     s_tdata  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [DATA_W-1:0]       m_tdata;

	ramp_req_t               req_q[$];
	logic [DATA_W-1:0]       velocity_q[$];
	ramp_req_t               req_on_bus;
	int                      n_sent     = 0;
	int                      n_recv     = 0;
	int                      n_err      = 0;
	int                      hold_left  = 0;
	bit                      hold_done  = 1'b0;
	int                      quiet_cnt  = 0;

	ramp_velocity_update_top #(
		.FRAC_BITS (FRAC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Integer square root, settled one bit at a time from the top.
	function automatic logic [DATA_W-1:0] floor_sqrt(logic [NUM_W-1:0] radicand);
		logic [DATA_W-1:0] root;
		logic [DATA_W-1:0] trial;
		root = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			trial = root | (DATA_W'(1) << i);
			if (NUM_W'(trial) * NUM_W'(trial) <= radicand)
				root = trial;
		end
		return root;
	endfunction

	// Velocity after the requested steps, with the sum held wide enough to
	// never wrap.
	function automatic logic [DATA_W-1:0] predict_velocity(ramp_req_t req);
		logic [127:0] accel_term;
		logic [127:0] v_sq;
		logic [127:0] radicand;
		if (req.rate == 0 || req.steps == 0 || req.cur_v == req.tgt_v)
			return req.cur_v;
		accel_term = (128'(req.rate) * 128'(req.steps)) << (FRAC_BITS + 1);
		v_sq = 128'(req.cur_v) * 128'(req.cur_v);
		if (req.cur_v < req.tgt_v) begin
			radicand = v_sq + accel_term;
			if (radicand >> NUM_W != 0)
				return ALL_ONES;
		end else begin
			if (accel_term >= v_sq)
				return '0;
			radicand = v_sq - accel_term;
		end
		return floor_sqrt(radicand[NUM_W-1:0]);
	endfunction

	function automatic ramp_req_t make_req(logic [DATA_W-1:0] rate, logic [DATA_W-1:0] cur_v,
			logic [DATA_W-1:0] tgt_v, logic [DATA_W-1:0] steps);
		ramp_req_t req;
		req.rate  = rate;
		req.cur_v = cur_v;
		req.tgt_v = tgt_v;
		req.steps = steps;
		return req;
	endfunction

	// Sender: presents queued requests, idles at random, and pauses once
	// until every predicted velocity has come back.
	always @(posedge clk or negedge arst_n) begin : sender
		bit fire;
		bit idle;
		bit drain_wait;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				velocity_q.push_back(predict_velocity(req_on_bus));
				n_sent++;
			end
			if (!s_tvalid || fire) begin
				idle = (n_sent >= CALM_FIRST && n_sent < CALM_LAST) ? 1'b0
					: ($urandom_range(0, 99) < IDLE_PCT);
				drain_wait = (n_sent == DRAIN_POINT) && (velocity_q.size() != 0);
				if (req_q.size() != 0 && !idle && !drain_wait) begin
					req_on_bus = req_q.pop_front();
					s_tdata  <= req_on_bus;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: scores each output beat and holds off once for a long stretch
	// so the chain fills and back-pressures the input.
	always @(posedge clk or negedge arst_n) begin : receiver
		logic [DATA_W-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (velocity_q.size() == 0) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("unexpected beat: new_velocity=%h", m_tdata);
				end else begin
					want = velocity_q.pop_front();
					if (m_tdata !== want) begin
						n_err++;
						if (n_err <= MAX_REPORTS)
							$display("beat %0d: new_velocity expected %h, got %h",
								n_recv, want, m_tdata);
					end
				end
				n_recv++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && n_recv == HOLD_POINT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (n_recv >= CALM_FIRST && n_recv < CALM_LAST) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog on cycles with no beat moving on either channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cnt <= 0;
		else
			quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int                cat;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] s;
		logic [NUM_W-1:0]  span;

		// Zero and all-ones fields, each bypass and both directions.
		req_q.push_back(make_req('0, '0, '0, '0));
		req_q.push_back(make_req('0, ALL_ONES, '0, 32'd5));
		req_q.push_back(make_req(32'd7, 32'd100, 32'd200, '0));
		req_q.push_back(make_req(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
		req_q.push_back(make_req(32'd1, '0, 32'd1, 32'd1));
		req_q.push_back(make_req(ALL_ONES, '0, ALL_ONES, ALL_ONES));
		req_q.push_back(make_req(32'd1, ALL_ONES - 1, ALL_ONES, 32'd1));
		req_q.push_back(make_req(32'd1, ALL_ONES, '0, 32'd1));
		// Deceleration that lands exactly on zero, and one step short of it.
		req_q.push_back(make_req(32'd1, 32'd8192, '0, 32'd8192));
		req_q.push_back(make_req(32'd1, 32'd8192, '0, 32'd8191));
		// Deceleration whose term is far beyond the squared velocity.
		req_q.push_back(make_req(ALL_ONES, ALL_ONES, '0, ALL_ONES));
		req_q.push_back(make_req(32'd1, 32'd1, '0, 32'd1));
		// Acceleration with the sum exactly at, and just under, 2^64.
		req_q.push_back(make_req(32'h8000_0000, '0, 32'd5, 32'h0010_0000));
		req_q.push_back(make_req(32'h8000_0000, 32'h0040_0000, ALL_ONES, 32'h000F_FFFF));
		req_q.push_back(make_req(32'h8000_0000, 32'h003F_FFFF, ALL_ONES, 32'h000F_FFFF));
		req_q.push_back(make_req(32'h8000_0000, '0, 32'd9, 32'h000F_FFFF));
		req_q.push_back(make_req(ALL_ONES, '0, ALL_ONES, 32'd1));
		req_q.push_back(make_req(32'd1, 32'd1, 32'd2, ALL_ONES));
		req_q.push_back(make_req(32'hAAAA_AAAA, 32'h5555_5555, ALL_ONES, 32'd3));
		req_q.push_back(make_req(32'h5555_5555, 32'hAAAA_AAAA, '0, 32'd2));

		for (int n = 0; n < N_RANDOM; n++) begin
			cat = $urandom_range(0, 9);
			a = $urandom;
			v = $urandom;
			t = $urandom;
			s = $urandom;
			case (cat)
				0, 1: begin
				end
				2, 3, 4: begin
					// Ramps of ordinary size in either direction.
					a = $urandom_range(1, 32'h000F_FFFF);
					s = $urandom_range(1, 64);
					v = $urandom_range(0, 32'h0FFF_FFFF);
					t = $urandom_range(0, 32'h0FFF_FFFF);
				end
				5: begin
					t = v;
				end
				6: begin
					if ($urandom_range(0, 1))
						a = '0;
					else
						s = '0;
				end
				7: begin
					// Deceleration ending close to zero on either side.
					v = $urandom_range(0, 32'h0010_0000);
					a = $urandom_range(1, 16);
					t = $urandom_range(0, 1) ? '0 : v;
					if (t == v && v != 0)
						t = v - 1;
					span = ((NUM_W'(v) * NUM_W'(v)) >> (FRAC_BITS + 1)) / a;
					s = DATA_W'(span) + DATA_W'($urandom_range(0, 4)) - DATA_W'(2);
					if (s > DATA_W'(span) + 2)
						s = 32'd1;
				end
				8: begin
					// Acceleration near saturation.
					v = $urandom_range(32'hC000_0000, ALL_ONES - 1);
					t = ALL_ONES;
					a = $urandom_range(1, 32'h0000_FFFF);
					s = $urandom_range(1, 32'h0000_FFFF);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: a = $urandom_range(0, 1) ? '0 : ALL_ONES;
						1: v = $urandom_range(0, 1) ? '0 : ALL_ONES;
						2: t = $urandom_range(0, 1) ? '0 : ALL_ONES;
						default: s = $urandom_range(0, 1) ? '0 : ALL_ONES;
					endcase
				end
			endcase
			req_q.push_back(make_req(a, v, t, s));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (velocity_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 16) @(posedge clk);

		if (velocity_q.size() != 0)
			n_err++;
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
